// ----- rtl/access_level_table_top_macros.svh -----
// Assertion helpers used by the RTL (alt_table). Clock is clk, reset is rst_n (active low).
`ifndef ACCESS_LEVEL_TABLE_TOP_MACROS_SVH
`define ACCESS_LEVEL_TABLE_TOP_MACROS_SVH

// Property checked every cycle outside reset.
`define ALT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property whose consequent holds in the cycle after the trigger.
`define ALT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/alt_pkg.sv -----
`default_nettype none
package alt_pkg;

  localparam int CMD_W = 4;
  localparam int KEY_W = 64;
  localparam int LVL_W = 4;
  localparam int DEV_W = 7;
  localparam int ST_W  = 3;
  localparam int CNT_W = 5;

  localparam int unsigned DEC_BASE = 10;

  localparam logic [CMD_W-1:0] CMD_ADD_KEY = 4'd0;
  localparam logic [CMD_W-1:0] CMD_DEL_KEY = 4'd1;
  localparam logic [CMD_W-1:0] CMD_CHG_KEY = 4'd2;
  localparam logic [CMD_W-1:0] CMD_ADD_DEV = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_DEV = 4'd4;
  localparam logic [CMD_W-1:0] CMD_CHG_DEV = 4'd5;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_CLR_KEY = 4'd7;
  localparam logic [CMD_W-1:0] CMD_CLR_DEV = 4'd8;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
  localparam logic [ST_W-1:0] ST_DUP     = 3'd3;
  localparam logic [ST_W-1:0] ST_NO_DEV  = 3'd4;
  localparam logic [ST_W-1:0] ST_NO_KEY  = 3'd5;
  localparam logic [ST_W-1:0] ST_DENIED  = 3'd6;

  // per-table commands from the controller
  typedef struct packed {
    logic srch;
    logic shift;
    logic append;
    logic update;
    logic clear;
  } tbl_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             hit;
    logic             full;
    logic [LVL_W-1:0] lvl;
  } tbl_sts_t;

  typedef struct packed {
    logic            take;
    tbl_cmd_t        ktbl;
    tbl_cmd_t        dtbl;
    logic            st_ld;
    logic [ST_W-1:0] st_code;
    logic            out_ld;
  } ctl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             key_ok;
    logic             dev_ok;
    logic             lvl_ok;
    logic             lvl_ge;
    logic             out_free;
    tbl_sts_t         ktbl;
    tbl_sts_t         dtbl;
  } ctl_sts_t;

  // 10^digits - 1, digits capped at 9
  function automatic int unsigned dec_limit(int unsigned digits);
    int unsigned lim;
    lim = 1;
    for (int unsigned i = 0; i < digits && i < 9; i++) begin
      lim = lim * DEC_BASE;
    end
    return lim - 1;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/alt_ram.sv -----
`default_nettype none
module alt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- rtl/alt_table.sv -----
`default_nettype none
`include "access_level_table_top_macros.svh"
module alt_table #(
  parameter int SLOTS = 16,
  parameter int TAG_W = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire alt_pkg::tbl_cmd_t             cmd_i,
  input  wire logic [TAG_W-1:0]              tag_i,
  input  wire logic [alt_pkg::LVL_W-1:0]     lvl_i,
  output alt_pkg::tbl_sts_t                  sts_o,
  output logic      [$clog2(SLOTS+1)-1:0]    cnt_o
);

  localparam int LW = alt_pkg::LVL_W;
  localparam int EW = TAG_W + LW;
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;
  logic          srch_r, srch_nxt;
  logic          shf_r, shf_nxt;
  logic          hit_r, hit_nxt;
  logic [IW-1:0] fidx_r, fidx_nxt;
  logic [IW-1:0] widx_r, widx_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;

  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [IW-1:0] raddr;
  logic [EW-1:0] rdata;
  logic          rd_go;
  logic          hit_now;

  alt_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // one read a cycle; data for the previous read compared/moved this cycle
  assign rd_go   = idx_r < cnt_r;
  assign hit_now = srch_r && pend_r && (rdata[EW-1:LW] == tag_i);

  always_comb begin
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    pend_nxt = 1'b0;
    srch_nxt = srch_r;
    shf_nxt  = shf_r;
    hit_nxt  = hit_r;
    fidx_nxt = fidx_r;
    widx_nxt = widx_r;
    lvl_nxt  = lvl_r;
    we       = 1'b0;
    waddr    = fidx_r;
    wdata    = {tag_i, lvl_i};
    raddr    = idx_r[IW-1:0];
    if (cmd_i.srch) begin
      idx_nxt  = '0;
      srch_nxt = 1'b1;
      hit_nxt  = 1'b0;
    end else if (cmd_i.shift) begin
      idx_nxt = CW'(fidx_r) + CW'(1);
      shf_nxt = 1'b1;
    end else if (srch_r) begin
      if (hit_now) begin
        hit_nxt  = 1'b1;
        fidx_nxt = IW'(idx_r - CW'(1));
        lvl_nxt  = rdata[LW-1:0];
        srch_nxt = 1'b0;
      end else if (rd_go) begin
        idx_nxt  = idx_r + CW'(1);
        pend_nxt = 1'b1;
      end else if (!pend_r) begin
        srch_nxt = 1'b0;
      end
    end else if (shf_r) begin
      // entry read last cycle drops one place
      if (pend_r) begin
        we    = 1'b1;
        waddr = widx_r;
        wdata = rdata;
      end
      if (rd_go) begin
        idx_nxt  = idx_r + CW'(1);
        pend_nxt = 1'b1;
        widx_nxt = IW'(idx_r - CW'(1));
      end else if (!pend_r) begin
        shf_nxt = 1'b0;
        cnt_nxt = cnt_r - CW'(1);
      end
    end else if (cmd_i.append) begin
      we      = 1'b1;
      waddr   = cnt_r[IW-1:0];
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd_i.update) begin
      we = 1'b1;
    end else if (cmd_i.clear) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      idx_r  <= '0;
      pend_r <= 1'b0;
      srch_r <= 1'b0;
      shf_r  <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      idx_r  <= idx_nxt;
      pend_r <= pend_nxt;
      srch_r <= srch_nxt;
      shf_r  <= shf_nxt;
      hit_r  <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fidx_r <= fidx_nxt;
    widx_r <= widx_nxt;
    lvl_r  <= lvl_nxt;
  end

  assign sts_o.busy = srch_r || shf_r;
  assign sts_o.hit  = hit_r;
  assign sts_o.full = (cnt_r == CW'(SLOTS));
  assign sts_o.lvl  = lvl_r;
  assign cnt_o      = cnt_r;

  `ALT_ASSERT(a_one_walk, !(srch_r && shf_r), "search and shift overlap")
  `ALT_ASSERT(a_cnt_bound, cnt_r <= CW'(SLOTS), "entry count above slot count")
  `ALT_ASSERT(a_no_overflow, !(cmd_i.append && cnt_r == CW'(SLOTS)), "append to full table")
  `ALT_ASSERT_NEXT(a_shift_hit, cmd_i.shift, shf_r && hit_r, "shift without a found entry")

endmodule
`default_nettype wire

// ----- rtl/alt_dpath.sv -----
`default_nettype none
module alt_dpath #(
  parameter int KEY_SLOTS        = 16,
  parameter int DEVICE_SLOTS     = 16,
  parameter int KEY_BYTES        = 8,
  parameter int DEVICE_ID_DIGITS = 2,
  parameter int LEVEL_DIGITS     = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [alt_pkg::CMD_W-1:0]     in_command,
  input  wire logic [alt_pkg::KEY_W-1:0]     in_key_value,
  input  wire logic [alt_pkg::LVL_W-1:0]     in_level,
  input  wire logic [alt_pkg::DEV_W-1:0]     in_device_id,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output logic      [alt_pkg::ST_W-1:0]      out_status,
  output logic      [alt_pkg::CNT_W-1:0]     out_key_count,
  output logic      [alt_pkg::CNT_W-1:0]     out_device_count,
  input  wire alt_pkg::ctl_cmd_t             ctl_i,
  output alt_pkg::ctl_sts_t                  sts_o
);

  localparam int          KW      = 8 * KEY_BYTES;
  localparam int          KCW     = $clog2(KEY_SLOTS + 1);
  localparam int          DCW     = $clog2(DEVICE_SLOTS + 1);
  localparam int unsigned DEV_MAX = alt_pkg::dec_limit(DEVICE_ID_DIGITS);
  localparam int unsigned LVL_MAX = alt_pkg::dec_limit(LEVEL_DIGITS);

  logic [alt_pkg::CMD_W-1:0] cmd_r;
  logic [KW-1:0]             key_r;
  logic [alt_pkg::LVL_W-1:0] lvl_r;
  logic [alt_pkg::DEV_W-1:0] dev_r;
  logic [alt_pkg::ST_W-1:0]  st_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [alt_pkg::ST_W-1:0]  out_status_r;
  logic [alt_pkg::CNT_W-1:0] out_kcnt_r;
  logic [alt_pkg::CNT_W-1:0] out_dcnt_r;

  alt_pkg::tbl_sts_t ksts;
  alt_pkg::tbl_sts_t dsts;
  logic [KCW-1:0]    kcnt;
  logic [DCW-1:0]    dcnt;
  logic              key_ok;

  alt_table #(.SLOTS(KEY_SLOTS), .TAG_W(KW)) u_ktbl (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd_i (ctl_i.ktbl),
    .tag_i (key_r),
    .lvl_i (lvl_r),
    .sts_o (ksts),
    .cnt_o (kcnt)
  );

  alt_table #(.SLOTS(DEVICE_SLOTS), .TAG_W(alt_pkg::DEV_W)) u_dtbl (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd_i (ctl_i.dtbl),
    .tag_i (dev_r),
    .lvl_i (lvl_r),
    .sts_o (dsts),
    .cnt_o (dcnt)
  );

  // no zero byte allowed in the key
  always_comb begin
    key_ok = 1'b1;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (key_r[8*b +: 8] == 8'h00) begin
        key_ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.take) begin
      cmd_r <= in_command;
      key_r <= in_key_value[KW-1:0];
      lvl_r <= in_level;
      dev_r <= in_device_id;
    end
    if (ctl_i.st_ld) begin
      st_r <= ctl_i.st_code;
    end
    if (ctl_i.out_ld) begin
      out_status_r <= st_r;
      out_kcnt_r   <= alt_pkg::CNT_W'(kcnt);
      out_dcnt_r   <= alt_pkg::CNT_W'(dcnt);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl_i.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts_o.cmd      = cmd_r;
  assign sts_o.key_ok   = key_ok;
  assign sts_o.dev_ok   = (dev_r != '0) && (32'(dev_r) <= DEV_MAX);
  assign sts_o.lvl_ok   = 32'(lvl_r) <= LVL_MAX;
  assign sts_o.lvl_ge   = ksts.lvl >= dsts.lvl;
  assign sts_o.out_free = !out_valid_r || !out_stall;
  assign sts_o.ktbl     = ksts;
  assign sts_o.dtbl     = dsts;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_key_count    = out_kcnt_r;
  assign out_device_count = out_dcnt_r;

endmodule
`default_nettype wire

// ----- rtl/alt_ctrl.sv -----
`default_nettype none
module alt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire alt_pkg::ctl_sts_t sts_i,
  output alt_pkg::ctl_cmd_t      ctl_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_SRCH  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    ctl_o     = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl_o.take = 1'b1;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        // argument checks; reject or clear straight away, or start the walks
        ctl_o.st_ld   = 1'b1;
        ctl_o.st_code = alt_pkg::ST_INVALID;
        state_nxt     = S_FIN;
        unique case (sts_i.cmd)
          alt_pkg::CMD_ADD_KEY: begin
            if (sts_i.key_ok && sts_i.lvl_ok) begin
              if (sts_i.ktbl.full) begin
                ctl_o.st_code = alt_pkg::ST_FULL;
              end else begin
                ctl_o.st_ld     = 1'b0;
                ctl_o.ktbl.srch = 1'b1;
                state_nxt       = S_SRCH;
              end
            end
          end
          alt_pkg::CMD_DEL_KEY: begin
            if (sts_i.key_ok) begin
              ctl_o.st_ld     = 1'b0;
              ctl_o.ktbl.srch = 1'b1;
              state_nxt       = S_SRCH;
            end
          end
          alt_pkg::CMD_CHG_KEY: begin
            if (sts_i.key_ok && sts_i.lvl_ok) begin
              ctl_o.st_ld     = 1'b0;
              ctl_o.ktbl.srch = 1'b1;
              state_nxt       = S_SRCH;
            end
          end
          alt_pkg::CMD_ADD_DEV: begin
            if (sts_i.dev_ok && sts_i.lvl_ok) begin
              if (sts_i.dtbl.full) begin
                ctl_o.st_code = alt_pkg::ST_FULL;
              end else begin
                ctl_o.st_ld     = 1'b0;
                ctl_o.dtbl.srch = 1'b1;
                state_nxt       = S_SRCH;
              end
            end
          end
          alt_pkg::CMD_DEL_DEV: begin
            if (sts_i.dev_ok) begin
              ctl_o.st_ld     = 1'b0;
              ctl_o.dtbl.srch = 1'b1;
              state_nxt       = S_SRCH;
            end
          end
          alt_pkg::CMD_CHG_DEV: begin
            if (sts_i.dev_ok && sts_i.lvl_ok) begin
              ctl_o.st_ld     = 1'b0;
              ctl_o.dtbl.srch = 1'b1;
              state_nxt       = S_SRCH;
            end
          end
          alt_pkg::CMD_CHECK: begin
            // both tables searched side by side
            if (sts_i.dev_ok && sts_i.key_ok) begin
              ctl_o.st_ld     = 1'b0;
              ctl_o.ktbl.srch = 1'b1;
              ctl_o.dtbl.srch = 1'b1;
              state_nxt       = S_SRCH;
            end
          end
          alt_pkg::CMD_CLR_KEY: begin
            ctl_o.ktbl.clear = 1'b1;
            ctl_o.st_code    = alt_pkg::ST_OK;
          end
          alt_pkg::CMD_CLR_DEV: begin
            ctl_o.dtbl.clear = 1'b1;
            ctl_o.st_code    = alt_pkg::ST_OK;
          end
          default: begin
            ctl_o.st_code = alt_pkg::ST_INVALID;
          end
        endcase
      end
      S_SRCH: begin
        if (!sts_i.ktbl.busy && !sts_i.dtbl.busy) begin
          ctl_o.st_ld   = 1'b1;
          ctl_o.st_code = alt_pkg::ST_OK;
          state_nxt     = S_FIN;
          unique case (sts_i.cmd)
            alt_pkg::CMD_ADD_KEY: begin
              if (sts_i.ktbl.hit) ctl_o.st_code = alt_pkg::ST_DUP;
              else ctl_o.ktbl.append = 1'b1;
            end
            alt_pkg::CMD_DEL_KEY: begin
              if (sts_i.ktbl.hit) begin
                ctl_o.st_ld      = 1'b0;
                ctl_o.ktbl.shift = 1'b1;
                state_nxt        = S_SHIFT;
              end else begin
                ctl_o.st_code = alt_pkg::ST_NO_KEY;
              end
            end
            alt_pkg::CMD_CHG_KEY: begin
              if (sts_i.ktbl.hit) ctl_o.ktbl.update = 1'b1;
              else ctl_o.st_code = alt_pkg::ST_NO_KEY;
            end
            alt_pkg::CMD_ADD_DEV: begin
              if (sts_i.dtbl.hit) ctl_o.st_code = alt_pkg::ST_DUP;
              else ctl_o.dtbl.append = 1'b1;
            end
            alt_pkg::CMD_DEL_DEV: begin
              if (sts_i.dtbl.hit) begin
                ctl_o.st_ld      = 1'b0;
                ctl_o.dtbl.shift = 1'b1;
                state_nxt        = S_SHIFT;
              end else begin
                ctl_o.st_code = alt_pkg::ST_NO_DEV;
              end
            end
            alt_pkg::CMD_CHG_DEV: begin
              if (sts_i.dtbl.hit) ctl_o.dtbl.update = 1'b1;
              else ctl_o.st_code = alt_pkg::ST_NO_DEV;
            end
            alt_pkg::CMD_CHECK: begin
              if (!sts_i.dtbl.hit) ctl_o.st_code = alt_pkg::ST_NO_DEV;
              else if (!sts_i.ktbl.hit) ctl_o.st_code = alt_pkg::ST_NO_KEY;
              else if (!sts_i.lvl_ge) ctl_o.st_code = alt_pkg::ST_DENIED;
            end
            default: begin
              ctl_o.st_code = alt_pkg::ST_INVALID;
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (!sts_i.ktbl.busy && !sts_i.dtbl.busy) begin
          ctl_o.st_ld   = 1'b1;
          ctl_o.st_code = alt_pkg::ST_OK;
          state_nxt     = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          ctl_o.out_ld = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

// ----- rtl/access_level_table_top.sv -----
// Access level table: two packed tables, one of keys and one of device ids, each
// entry carrying an access level. One command item in gives one result item out
// (status plus the key and device counts after the command). Items are handled one
// at a time. A command rejected by its checks, or a clear, is answered without a search;
// add, change and check search the table linearly at one table RAM read per cycle,
// stopping at the first match (check searches both tables in parallel and takes the
// longer walk), and a delete searches and then moves every later entry down one place
// through the same single read port. A finished result sits in the output register, so
// the next item is taken while it waits; only a result still stalled when the next one
// is ready holds the block. Tables need no clearing pass after reset; entries beyond the
// fill count are never read.
`default_nettype none
module access_level_table_top #(
  parameter int KEY_SLOTS        = 16,  // key table depth
  parameter int DEVICE_SLOTS     = 16,  // device table depth
  parameter int KEY_BYTES        = 8,   // low bytes of key_value that form the key
  parameter int DEVICE_ID_DIGITS = 2,   // device ids valid from 1 to 10^digits - 1
  parameter int LEVEL_DIGITS     = 1    // levels valid up to 10^digits - 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // command item
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [alt_pkg::CMD_W-1:0]     in_command,
  input  wire logic [alt_pkg::KEY_W-1:0]     in_key_value,
  input  wire logic [alt_pkg::LVL_W-1:0]     in_level,
  input  wire logic [alt_pkg::DEV_W-1:0]     in_device_id,
  // result item
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [alt_pkg::ST_W-1:0]      out_status,
  output logic      [alt_pkg::CNT_W-1:0]     out_key_count,
  output logic      [alt_pkg::CNT_W-1:0]     out_device_count
);

  alt_pkg::ctl_cmd_t ctl;
  alt_pkg::ctl_sts_t sts;

  // sequencer: argument checks, search, append/update/shift/clear, result hand-off
  alt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts_i    (sts),
    .ctl_o    (ctl)
  );

  // operand registers, both table RAMs with their walkers, output register
  alt_dpath #(
    .KEY_SLOTS        (KEY_SLOTS),
    .DEVICE_SLOTS     (DEVICE_SLOTS),
    .KEY_BYTES        (KEY_BYTES),
    .DEVICE_ID_DIGITS (DEVICE_ID_DIGITS),
    .LEVEL_DIGITS     (LEVEL_DIGITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_command),
    .in_key_value     (in_key_value),
    .in_level         (in_level),
    .in_device_id     (in_device_id),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_key_count    (out_key_count),
    .out_device_count (out_device_count),
    .ctl_i            (ctl),
    .sts_o            (sts)
  );

endmodule
`default_nettype wire

// ----- tb/sv/access_level_table_checker.sv -----
module access_level_table_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [alt_pkg::CMD_W-1:0] in_command,
  input  logic [alt_pkg::KEY_W-1:0] in_key_value,
  input  logic [alt_pkg::LVL_W-1:0] in_level,
  input  logic [alt_pkg::DEV_W-1:0] in_device_id,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [alt_pkg::ST_W-1:0]  out_status,
  input  logic [alt_pkg::CNT_W-1:0] out_key_count,
  input  logic [alt_pkg::CNT_W-1:0] out_device_count,
  output int                        fail_count,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_DEPTH = 16;
  localparam int DEV_DEPTH = 16;
  localparam int DEV_MAX   = 99;  // two decimal digits
  localparam int LVL_MAX   = 9;   // one decimal digit

  typedef struct packed {
    logic [alt_pkg::ST_W-1:0]  status;
    logic [alt_pkg::CNT_W-1:0] key_count;
    logic [alt_pkg::CNT_W-1:0] device_count;
  } access_result_t;

  logic [alt_pkg::KEY_W-1:0] key_tab [KEY_DEPTH];
  logic [alt_pkg::LVL_W-1:0] key_lvl [KEY_DEPTH];
  logic [alt_pkg::DEV_W-1:0] dev_tab [DEV_DEPTH];
  logic [alt_pkg::LVL_W-1:0] dev_lvl [DEV_DEPTH];
  int                        n_keys = 0;
  int                        n_devs = 0;

  access_result_t expected_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic bit key_ok(logic [alt_pkg::KEY_W-1:0] k);
    for (int i = 0; i < 8; i++) begin
      if (k[8*i +: 8] == 8'h00) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit dev_ok(logic [alt_pkg::DEV_W-1:0] d);
    return d >= 1 && d <= DEV_MAX;
  endfunction

  function automatic int find_key(logic [alt_pkg::KEY_W-1:0] k);
    for (int i = 0; i < n_keys; i++) begin
      if (key_tab[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic int find_dev(logic [alt_pkg::DEV_W-1:0] d);
    for (int i = 0; i < n_devs; i++) begin
      if (dev_tab[i] == d) return i;
    end
    return -1;
  endfunction

  function automatic void clear_key_table();
    for (int i = 0; i < KEY_DEPTH; i++) begin
      key_tab[i] = '0;
      key_lvl[i] = '0;
    end
    n_keys = 0;
  endfunction

  function automatic void clear_dev_table();
    for (int i = 0; i < DEV_DEPTH; i++) begin
      dev_tab[i] = '0;
      dev_lvl[i] = '0;
    end
    n_devs = 0;
  endfunction

  // Applies one command to the shadow tables and returns the result item.
  function automatic access_result_t predict_access(logic [alt_pkg::CMD_W-1:0] cmd,
                                                    logic [alt_pkg::KEY_W-1:0] key,
                                                    logic [alt_pkg::LVL_W-1:0] lvl,
                                                    logic [alt_pkg::DEV_W-1:0] dev);
    access_result_t r;
    int ki;
    int di;
    bit lvl_ok;
    r.status = alt_pkg::ST_OK;
    ki = find_key(key);
    di = find_dev(dev);
    lvl_ok = lvl <= LVL_MAX;
    case (cmd)
      alt_pkg::CMD_ADD_KEY: begin
        if (!key_ok(key) || !lvl_ok) r.status = alt_pkg::ST_INVALID;
        else if (n_keys >= KEY_DEPTH) r.status = alt_pkg::ST_FULL;
        else if (ki >= 0) r.status = alt_pkg::ST_DUP;
        else begin
          key_tab[n_keys] = key;
          key_lvl[n_keys] = lvl;
          n_keys++;
        end
      end
      alt_pkg::CMD_DEL_KEY: begin
        if (!key_ok(key)) r.status = alt_pkg::ST_INVALID;
        else if (ki < 0) r.status = alt_pkg::ST_NO_KEY;
        else begin
          for (int i = ki; i < n_keys - 1; i++) begin
            key_tab[i] = key_tab[i+1];
            key_lvl[i] = key_lvl[i+1];
          end
          n_keys--;
          key_tab[n_keys] = '0;
          key_lvl[n_keys] = '0;
        end
      end
      alt_pkg::CMD_CHG_KEY: begin
        if (!key_ok(key) || !lvl_ok) r.status = alt_pkg::ST_INVALID;
        else if (ki < 0) r.status = alt_pkg::ST_NO_KEY;
        else key_lvl[ki] = lvl;
      end
      alt_pkg::CMD_ADD_DEV: begin
        if (!dev_ok(dev) || !lvl_ok) r.status = alt_pkg::ST_INVALID;
        else if (n_devs >= DEV_DEPTH) r.status = alt_pkg::ST_FULL;
        else if (di >= 0) r.status = alt_pkg::ST_DUP;
        else begin
          dev_tab[n_devs] = dev;
          dev_lvl[n_devs] = lvl;
          n_devs++;
        end
      end
      alt_pkg::CMD_DEL_DEV: begin
        if (!dev_ok(dev)) r.status = alt_pkg::ST_INVALID;
        else if (di < 0) r.status = alt_pkg::ST_NO_DEV;
        else begin
          for (int i = di; i < n_devs - 1; i++) begin
            dev_tab[i] = dev_tab[i+1];
            dev_lvl[i] = dev_lvl[i+1];
          end
          n_devs--;
          dev_tab[n_devs] = '0;
          dev_lvl[n_devs] = '0;
        end
      end
      alt_pkg::CMD_CHG_DEV: begin
        if (!dev_ok(dev) || !lvl_ok) r.status = alt_pkg::ST_INVALID;
        else if (di < 0) r.status = alt_pkg::ST_NO_DEV;
        else dev_lvl[di] = lvl;
      end
      alt_pkg::CMD_CHECK: begin
        if (!dev_ok(dev) || !key_ok(key)) r.status = alt_pkg::ST_INVALID;
        else if (di < 0) r.status = alt_pkg::ST_NO_DEV;
        else if (ki < 0) r.status = alt_pkg::ST_NO_KEY;
        else if (key_lvl[ki] >= dev_lvl[di]) r.status = alt_pkg::ST_OK;
        else r.status = alt_pkg::ST_DENIED;
      end
      alt_pkg::CMD_CLR_KEY: clear_key_table();
      alt_pkg::CMD_CLR_DEV: clear_dev_table();
      default: r.status = alt_pkg::ST_INVALID;
    endcase
    r.key_count    = alt_pkg::CNT_W'(n_keys);
    r.device_count = alt_pkg::CNT_W'(n_devs);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    access_result_t want;
    if (!rst_n) begin
      clear_key_table();
      clear_dev_table();
      expected_results.delete();
    end else begin
      // results first: an item accepted this edge cannot have its result yet
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item: status %0d, key_count %0d, device_count %0d",
                 out_status, out_key_count, out_device_count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            fail_count++;
          end
          if (out_key_count !== want.key_count) begin
            $error("key_count: expected %0d, actual %0d", want.key_count, out_key_count);
            fail_count++;
          end
          if (out_device_count !== want.device_count) begin
            $error("device_count: expected %0d, actual %0d",
                   want.device_count, out_device_count);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(
          predict_access(in_command, in_key_value, in_level, in_device_id));
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- tb/sv/access_level_table_top_test.sv -----
module access_level_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Command codes the block does not define; all must be rejected as invalid.
  localparam logic [alt_pkg::CMD_W-1:0] CMD_FIRST_UNUSED = 4'd9;
  localparam logic [alt_pkg::CMD_W-1:0] CMD_LAST_UNUSED  = 4'd15;

  localparam int RANDOM_ITEMS = 1300;
  localparam int POOL         = 24;    // more names than slots, so tables fill up
  localparam int MAX_WAIT     = 16;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 60;

  // Directed keys: all bytes set, all bytes minimal, one never added.
  localparam logic [alt_pkg::KEY_W-1:0] KEY_ALL_FF = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [alt_pkg::KEY_W-1:0] KEY_ALL_01 = 64'h0101_0101_0101_0101;
  localparam logic [alt_pkg::KEY_W-1:0] KEY_ABSENT = 64'h4B45_5930_3031_2D41;
  // Invalid keys: a zero byte at the top, in the middle, at the bottom.
  localparam logic [alt_pkg::KEY_W-1:0] KEY_ZERO_HI  = 64'h0042_4344_4546_4748;
  localparam logic [alt_pkg::KEY_W-1:0] KEY_ZERO_MID = 64'h4142_4300_4546_4748;
  localparam logic [alt_pkg::KEY_W-1:0] KEY_ZERO_LO  = 64'h4142_4344_4546_4700;

  logic                      clk   = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [alt_pkg::CMD_W-1:0] in_command   = '0;
  logic [alt_pkg::KEY_W-1:0] in_key_value = '0;
  logic [alt_pkg::LVL_W-1:0] in_level     = '0;
  logic [alt_pkg::DEV_W-1:0] in_device_id = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [alt_pkg::ST_W-1:0]  out_status;
  logic [alt_pkg::CNT_W-1:0] out_key_count;
  logic [alt_pkg::CNT_W-1:0] out_device_count;

  int fail_count;
  int pending;

  logic [alt_pkg::KEY_W-1:0] key_pool [POOL];
  logic [alt_pkg::DEV_W-1:0] dev_pool [POOL];

  always #5 clk = ~clk;

  access_level_table_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_key_value     (in_key_value),
    .in_level         (in_level),
    .in_device_id     (in_device_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_key_count    (out_key_count),
    .out_device_count (out_device_count)
  );

  access_level_table_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_key_value     (in_key_value),
    .in_level         (in_level),
    .in_device_id     (in_device_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_key_count    (out_key_count),
    .out_device_count (out_device_count),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Idle cycles for one item; quiet stretches run back to back.
  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Mostly known keys; some with one byte zeroed, some fully random.
  function automatic logic [alt_pkg::KEY_W-1:0] pick_key();
    logic [alt_pkg::KEY_W-1:0] k;
    int sel;
    int b;
    sel = $urandom_range(0, 99);
    b   = $urandom_range(0, 7);
    k   = key_pool[$urandom_range(0, POOL-1)];
    if (sel >= 94) k = {$urandom, $urandom};
    else if (sel >= 86) k[8*b +: 8] = 8'h00;
    return k;
  endfunction

  // Mostly known devices; the rest anywhere in the 7-bit range (0 and >99 invalid).
  function automatic logic [alt_pkg::DEV_W-1:0] pick_dev();
    if ($urandom_range(0, 99) < 85) return dev_pool[$urandom_range(0, POOL-1)];
    return alt_pkg::DEV_W'($urandom_range(0, 127));
  endfunction

  // Levels mostly legal (0..9), sometimes 10..15.
  function automatic logic [alt_pkg::LVL_W-1:0] pick_level();
    if ($urandom_range(0, 99) < 88) return alt_pkg::LVL_W'($urandom_range(0, 9));
    return alt_pkg::LVL_W'($urandom_range(0, 15));
  endfunction

  // Adds outweigh deletes so both tables reach full; clears are rare.
  function automatic logic [alt_pkg::CMD_W-1:0] pick_command();
    int r;
    r = $urandom_range(0, 199);
    if (r < 50)  return alt_pkg::CMD_ADD_KEY;
    if (r < 100) return alt_pkg::CMD_ADD_DEV;
    if (r < 112) return alt_pkg::CMD_DEL_KEY;
    if (r < 124) return alt_pkg::CMD_DEL_DEV;
    if (r < 136) return alt_pkg::CMD_CHG_KEY;
    if (r < 148) return alt_pkg::CMD_CHG_DEV;
    if (r < 192) return alt_pkg::CMD_CHECK;
    if (r == 192) return alt_pkg::CMD_CLR_KEY;
    if (r == 193) return alt_pkg::CMD_CLR_DEV;
    return alt_pkg::CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
  endfunction

  // Present one command item. Called and returns at a falling edge. Valid is only
  // dropped when a gap is drawn, so back-to-back items keep it high.
  task automatic issue_command(logic [alt_pkg::CMD_W-1:0] cmd,
                               logic [alt_pkg::KEY_W-1:0] key,
                               logic [alt_pkg::LVL_W-1:0] lvl,
                               logic [alt_pkg::DEV_W-1:0] dev,
                               bit quiet);
    int gap;
    gap = draw_wait(quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_key_value <= key;
    in_level     <= lvl;
    in_device_id <= dev;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Result side: after each accepted result draw a stall, counted down only
  // while a result is offered, so stalls also sit across idle stretches and
  // hold a finished result while the block takes the next command.
  logic result_taken = 1'b0;
  int   stall_left   = 0;
  int   results_seen = 0;

  always @(posedge clk) result_taken <= out_valid && !out_stall;

  always @(negedge clk) begin
    if (result_taken) begin
      results_seen++;
      stall_left = draw_wait(((results_seen / 120) % 3) == 2);
    end else if (out_valid && stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  // Watchdog: cycles in a row with no item moving on either channel.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < POOL; i++) begin
      for (int b = 0; b < 8; b++) key_pool[i][8*b +: 8] = 8'($urandom_range(1, 255));
      dev_pool[i] = alt_pkg::DEV_W'($urandom_range(1, 99));
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty tables, argument limits, check order, shifts, clears.
    issue_command(alt_pkg::CMD_CHECK,   KEY_ALL_FF,   4'd0,  7'd99,  1'b1); // no device yet
    issue_command(alt_pkg::CMD_ADD_KEY, '0,           4'd1,  7'd0,   1'b1); // all-zero key
    issue_command(alt_pkg::CMD_ADD_KEY, KEY_ZERO_HI,  4'd1,  7'd5,   1'b1);
    issue_command(alt_pkg::CMD_ADD_KEY, KEY_ZERO_LO,  4'd9,  7'd5,   1'b1);
    issue_command(alt_pkg::CMD_ADD_KEY, KEY_ALL_FF,   4'd10, 7'd5,   1'b1); // level too high
    issue_command(alt_pkg::CMD_ADD_KEY, KEY_ALL_FF,   4'd9,  7'd127, 1'b0);
    issue_command(alt_pkg::CMD_ADD_KEY, KEY_ALL_01,   4'd0,  7'd0,   1'b0);
    issue_command(alt_pkg::CMD_ADD_KEY, KEY_ALL_FF,   4'd3,  7'd1,   1'b0); // duplicate
    issue_command(alt_pkg::CMD_ADD_DEV, KEY_ZERO_MID, 4'd1,  7'd0,   1'b0); // device 0
    issue_command(alt_pkg::CMD_ADD_DEV, '0,           4'd1,  7'd100, 1'b0); // past two digits
    issue_command(alt_pkg::CMD_ADD_DEV, '0,           4'd15, 7'd99,  1'b0); // level too high
    issue_command(alt_pkg::CMD_ADD_DEV, KEY_ZERO_LO,  4'd9,  7'd99,  1'b0);
    issue_command(alt_pkg::CMD_ADD_DEV, '0,           4'd0,  7'd1,   1'b0);
    issue_command(alt_pkg::CMD_ADD_DEV, '0,           4'd5,  7'd1,   1'b0); // duplicate
    issue_command(alt_pkg::CMD_CHECK,   KEY_ALL_FF,   4'd15, 7'd99,  1'b0); // equal grants
    issue_command(alt_pkg::CMD_CHECK,   KEY_ALL_01,   4'd0,  7'd99,  1'b0); // denied
    issue_command(alt_pkg::CMD_CHECK,   KEY_ABSENT,   4'd0,  7'd1,   1'b0); // key missing
    issue_command(alt_pkg::CMD_CHECK,   '0,           4'd0,  7'd0,   1'b0); // both invalid
    issue_command(alt_pkg::CMD_CHG_KEY, KEY_ALL_01,   4'd9,  7'd0,   1'b0);
    issue_command(alt_pkg::CMD_CHG_KEY, KEY_ABSENT,   4'd12, 7'd0,   1'b0); // level first
    issue_command(alt_pkg::CMD_CHG_DEV, '0,           4'd3,  7'd99,  1'b0);
    issue_command(alt_pkg::CMD_CHG_DEV, '0,           4'd3,  7'd42,  1'b0); // device missing
    issue_command(alt_pkg::CMD_DEL_KEY, KEY_ALL_FF,   4'd7,  7'd3,   1'b0); // shifts other
    issue_command(alt_pkg::CMD_DEL_KEY, KEY_ALL_FF,   4'd0,  7'd3,   1'b0); // now missing
    issue_command(alt_pkg::CMD_DEL_DEV, KEY_ALL_FF,   4'd0,  7'd99,  1'b0);
    issue_command(alt_pkg::CMD_DEL_DEV, '0,           4'd0,  7'd127, 1'b0);
    issue_command(CMD_FIRST_UNUSED, KEY_ALL_FF, 4'd1, 7'd1, 1'b0);
    issue_command(CMD_LAST_UNUSED,  KEY_ALL_FF, 4'd1, 7'd1, 1'b0);
    issue_command(alt_pkg::CMD_CLR_KEY, KEY_ALL_FF,   4'd15, 7'd127, 1'b0);
    issue_command(alt_pkg::CMD_CLR_DEV, '0,           4'd0,  7'd0,   1'b0);

    // Random: names from small pools so adds, deletes and checks mostly hit,
    // with a share of malformed operands and unused command codes.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      issue_command(pick_command(), pick_key(), pick_level(), pick_dev(),
                    ((n / 100) % 4) == 3);
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
